// ----- design/assert_macros.svh -----
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/taw_pkg.sv -----
package taw_pkg;

    localparam int WORD_W  = 16;
    localparam int OP_W    = 2;
    localparam int POS_W   = 9;
    localparam int COUNT_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_CHANNELS     = 2;
    localparam int DEF_WINDOW_WORDS = 510;

    localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
    localparam logic [OP_W-1:0] OP_REALIGN = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_BASE = 2'd2;

    localparam logic [WORD_W-1:0] RST_IDLE_TAG = 16'h0000;
    localparam logic [WORD_W-1:0] RST_TAG_MASK = 16'hFFFF;
    localparam logic [WORD_W-1:0] RST_TAG_BASE = 16'h0000;

endpackage

// ----- design/taw_ifs.sv -----
interface taw_in_if;
    import taw_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] sample_word;
    logic              transfer_start;
    modport source (output valid, operation, sample_word, transfer_start, input ready);
    modport sink   (input valid, operation, sample_word, transfer_start, output ready);
endinterface

interface taw_out_if;
    import taw_pkg::*;
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  out_word;
    logic [POS_W-1:0]   window_position;
    logic               window_last;
    logic [COUNT_W-1:0] windows_done;
    modport source (output valid, out_word, window_position, window_last, windows_done,
                    input ready);
    modport sink   (input valid, out_word, window_position, window_last, windows_done,
                    output ready);
endinterface

interface taw_cfg_if;
    import taw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/tag_aligned_window_assembler.sv -----
// A data item that passes is registered and shows on the result channel in the cycle after it is accepted.
// Throughput: one item per cycle; input ready drops only while a held result is stalled,
// the result register acting as the stage between the two sides.
// Reset (synchronous, active low): sync, transfer phase, window fill and window count
// clear; tag registers return to idle 0, mask 0xFFFF, base 0; no result pending.
module tag_aligned_window_assembler #(
    parameter int CHANNELS     = taw_pkg::DEF_CHANNELS,
    parameter int WINDOW_WORDS = taw_pkg::DEF_WINDOW_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    taw_in_if.sink      i_in,
    taw_out_if.source   o_res,
    taw_cfg_if.sink     i_cfg
);
    import taw_pkg::*;

    localparam int PHASE_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FILL_W  = $clog2(WINDOW_WORDS);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CHANNELS - 1);
    localparam logic [FILL_W-1:0]  FILL_LAST  = FILL_W'(WINDOW_WORDS - 1);

    logic [WORD_W-1:0]  r_idle_tag;
    logic [WORD_W-1:0]  r_tag_mask;
    logic [WORD_W-1:0]  r_tag_base;

    logic               r_synced,  n_synced;
    logic [PHASE_W-1:0] r_phase,   n_phase;
    logic [FILL_W-1:0]  r_fill,    n_fill;
    logic [COUNT_W-1:0] r_total,   n_total;

    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;
    logic [COUNT_W-1:0] r_out_done;

    logic               in_acc;
    logic               n_emit;
    logic               n_last;
    logic [PHASE_W-1:0] cur_phase;
    logic               is_tag;
    logic [FILL_W+POS_W-1:0] fill_ext;

    assign i_in.ready  = !r_out_valid || o_res.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign is_tag = (i_in.sample_word == r_idle_tag) ||
                    ((i_in.sample_word & r_tag_mask) == r_tag_base);
    assign cur_phase = i_in.transfer_start ? '0 : r_phase;
    assign fill_ext  = {{POS_W{1'b0}}, r_fill};

    always_comb begin
        n_synced = r_synced;
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_total  = r_total;
        n_emit   = 1'b0;
        n_last   = 1'b0;
        case (i_in.operation)
            OP_REALIGN: begin
                n_synced = 1'b0;
                n_fill   = '0;
                n_phase  = '0;
            end
            OP_CLEAR: begin
                n_total = '0;
            end
            OP_DATA: begin
                n_phase = (cur_phase == PHASE_LAST) ? '0 : cur_phase + PHASE_W'(1);
                // once synced every word passes; before that only a tag on a group start
                if (r_synced || (cur_phase == '0 && is_tag)) begin
                    n_synced = 1'b1;
                    n_emit   = 1'b1;
                    n_last   = (r_fill == FILL_LAST);
                    if (n_last) begin
                        n_fill  = '0;
                        n_total = r_total + COUNT_W'(1);
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_tag  <= RST_IDLE_TAG;
            r_tag_mask  <= RST_TAG_MASK;
            r_tag_base  <= RST_TAG_BASE;
            r_synced    <= 1'b0;
            r_phase     <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_IDLE_TAG: r_idle_tag <= i_cfg.data;
                    REG_TAG_MASK: r_tag_mask <= i_cfg.data;
                    REG_TAG_BASE: r_tag_base <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_synced    <= n_synced;
                r_phase     <= n_phase;
                r_fill      <= n_fill;
                r_total     <= n_total;
                r_out_valid <= n_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_out_word <= i_in.sample_word;
            r_out_pos  <= fill_ext[POS_W-1:0];
            r_out_last <= n_last;
            r_out_done <= n_total;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.out_word        = r_out_word;
    assign o_res.window_position = r_out_pos;
    assign o_res.window_last     = r_out_last;
    assign o_res.windows_done    = r_out_done;

endmodule

// ----- design/taw_checker.sv -----
`include "assert_macros.svh"

module taw_checker #(
    parameter int WINDOW_WORDS = taw_pkg::DEF_WINDOW_WORDS
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [taw_pkg::OP_W-1:0]    i_in_operation,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [taw_pkg::POS_W-1:0]   i_out_position,
    input logic                        i_out_last
);
    import taw_pkg::*;

    localparam int LAST_EXT = WINDOW_WORDS - 1;
    localparam logic [POS_W-1:0] LAST_POS = LAST_EXT[POS_W-1:0];

    logic in_acc;
    logic out_stall;
    logic ctrl_acc;
    logic last_out;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign ctrl_acc  = in_acc && (i_in_operation == OP_REALIGN || i_in_operation == OP_CLEAR);
    assign last_out  = i_out_valid && i_out_last;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid, "result dropped")
    `ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input blocked")
    // realign and clear produce nothing, so the output drains behind them
    `ASSERT_NEXT(a_ctrl_no_result, i_clk, i_rst_n, ctrl_acc, !i_out_valid, "control result")
    `ASSERT_IMPLY(a_last_pos, i_clk, i_rst_n, last_out, i_out_position == LAST_POS, "window end")

endmodule

bind tag_aligned_window_assembler taw_checker #(
    .WINDOW_WORDS(WINDOW_WORDS)
) u_taw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_position (o_res.window_position),
    .i_out_last     (o_res.window_last)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import taw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CHANNELS      = DEF_CHANNELS;
    localparam int WINDOW_WORDS  = DEF_WINDOW_WORDS;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRESSURE_AT   = 270;
    localparam int IDLE_BLOCK    = 60;
    localparam int NUM_ROWS      = 17;
    localparam int NUM_PHASES    = 5;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [POS_W-1:0]   pos;
        logic               last;
        logic [COUNT_W-1:0] done;
    } t_window_word;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] word;
        logic              start;
        logic              typed;
        logic              has_res;
        t_window_word      res;
    } t_stim_row;

    typedef struct packed {
        logic [WORD_W-1:0] idle;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] base;
        logic [15:0]       items;
        logic [7:0]        realign_pct;
        logic              resync;
        logic              rnd;
    } t_tag_phase;

    localparam t_window_word NO_RES = '0;

    // Reset tag settings: only word 0 matches.
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        // position counts from 0 after reset, no transfer start needed
        '{OP_DATA,    16'h0000, 1'b0, 1'b1, 1'b1, '{16'h0000, 9'd0, 1'b0, 32'd0}},
        '{OP_DATA,    16'hFFFF, 1'b0, 1'b1, 1'b1, '{16'hFFFF, 9'd1, 1'b0, 32'd0}},
        '{OP_UNUSED,  16'hFFFF, 1'b1, 1'b1, 1'b0, NO_RES},
        '{OP_CLEAR,   16'hFFFF, 1'b1, 1'b1, 1'b0, NO_RES},
        '{OP_DATA,    16'h8001, 1'b1, 1'b1, 1'b1, '{16'h8001, 9'd2, 1'b0, 32'd0}},
        '{OP_REALIGN, 16'hFFFF, 1'b1, 1'b1, 1'b0, NO_RES},
        '{OP_DATA,    16'hFFFF, 1'b1, 1'b1, 1'b0, NO_RES},
        // tag value on an odd position is not looked at
        '{OP_DATA,    16'h0000, 1'b0, 1'b1, 1'b0, NO_RES},
        '{OP_DATA,    16'h0000, 1'b0, 1'b1, 1'b1, '{16'h0000, 9'd0, 1'b0, 32'd0}},
        '{OP_DATA,    16'h1234, 1'b1, 1'b0, 1'b0, NO_RES},
        '{OP_REALIGN, 16'h0000, 1'b0, 1'b1, 1'b0, NO_RES},
        '{OP_DATA,    16'h1111, 1'b1, 1'b1, 1'b0, NO_RES},
        // transfer start forces the channel phase back to 0
        '{OP_DATA,    16'h0000, 1'b1, 1'b1, 1'b1, '{16'h0000, 9'd0, 1'b0, 32'd0}},
        '{OP_DATA,    16'hABCD, 1'b0, 1'b0, 1'b0, NO_RES},
        '{OP_DATA,    16'h5432, 1'b1, 1'b0, 1'b0, NO_RES},
        '{OP_CLEAR,   16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{OP_DATA,    16'h7FFF, 1'b0, 1'b0, 1'b0, NO_RES}
    };

    // First phase keeps the fill going long enough to close a window.
    localparam t_tag_phase PHASES [NUM_PHASES] = '{
        '{16'h0000, 16'hFFFF, 16'h0000, 16'd600, 8'd0, 1'b0, 1'b0},
        '{16'hFFFF, 16'h0000, 16'h0000, 16'd90,  8'd5, 1'b1, 1'b0},
        '{16'h8000, 16'hFF00, 16'hA500, 16'd90,  8'd4, 1'b1, 1'b0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd85,  8'd4, 1'b1, 1'b0},
        '{16'h0000, 16'h0000, 16'h0000, 16'd85,  8'd4, 1'b1, 1'b1}
    };

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [3] = '{REG_IDLE_TAG, REG_TAG_MASK, REG_TAG_BASE};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_off;

    taw_in_if  in_ch ();
    taw_out_if res_ch ();
    taw_cfg_if cfg_ch ();

    tag_aligned_window_assembler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state and tag settings
    logic [WORD_W-1:0]  idle_tag_q, tag_mask_q, tag_base_q;
    logic               synced_q;
    logic [3:0]         phase_q;
    logic [POS_W-1:0]   fill_q;
    logic [COUNT_W-1:0] windows_q;

    t_window_word pending_words [$];
    int fail_count = 0;
    int items_in = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;

    function automatic bit assemble_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] w,
                                         input logic start, output t_window_word r);
        logic [3:0] cur;
        r = '0;
        case (op)
            OP_REALIGN: begin
                synced_q = 1'b0;
                fill_q = '0;
                phase_q = '0;
                return 1'b0;
            end
            OP_CLEAR: begin
                windows_q = '0;
                return 1'b0;
            end
            OP_DATA: ;
            default: return 1'b0;
        endcase
        cur = start ? 4'd0 : phase_q;
        phase_q = (int'(cur) + 1 >= CHANNELS) ? 4'd0 : cur + 4'd1;
        if (!synced_q) begin
            if (cur != 4'd0 || !(w == idle_tag_q || (w & tag_mask_q) == tag_base_q))
                return 1'b0;
            synced_q = 1'b1;
        end
        r.word = w;
        r.pos  = fill_q;
        r.last = 1'b0;
        if (int'(fill_q) + 1 >= WINDOW_WORDS) begin
            r.last = 1'b1;
            fill_q = '0;
            windows_q = windows_q + 32'd1;
        end else begin
            fill_q = fill_q + 9'd1;
        end
        r.done = windows_q;
        return 1'b1;
    endfunction

    // Bias toward words that hit a tag so sync search gets exercised.
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] noise;
        noise = WORD_W'($urandom);
        case ($urandom_range(3))
            0:       return idle_tag_q;
            1:       return (tag_base_q & tag_mask_q) | (noise & ~tag_mask_q);
            default: return noise;
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] w,
                             input logic start, input logic typed, input logic typed_has,
                             input t_window_word typed_res);
        t_window_word pred;
        bit has;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= op;
        in_ch.sample_word    <= w;
        in_ch.transfer_start <= start;
        do @(posedge i_clk); while (!in_ch.ready);
        has = assemble_word(op, w, start, pred);
        if (typed) begin
            has = typed_has;
            pred = typed_res;
        end
        if (has)
            pending_words.push_back(pred);
        items_in++;
    endtask

    task automatic write_tags(input logic [WORD_W-1:0] idle, input logic [WORD_W-1:0] mask,
                              input logic [WORD_W-1:0] base);
        logic [WORD_W-1:0] vals [3];
        vals = '{idle, mask, base};
        for (int i = 0; i < 3; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= REG_ORDER[i];
            cfg_ch.data  <= vals[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (REG_ORDER[i])
                REG_IDLE_TAG: idle_tag_q = vals[i];
                REG_TAG_MASK: tag_mask_q = vals[i];
                REG_TAG_BASE: tag_base_q = vals[i];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Long receiver hold-off while the sender keeps offering items
    initial begin
        hold_off <= 1'b0;
        wait (items_in >= PRESSURE_AT);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_window_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result item: out_word %h", res_ch.out_word);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                if (res_ch.out_word !== want.word) begin
                    $error("out_word: expected %h, got %h", want.word, res_ch.out_word);
                    fail_count++;
                end
                if (res_ch.window_position !== want.pos) begin
                    $error("window_position: expected %0d, got %0d",
                           want.pos, res_ch.window_position);
                    fail_count++;
                end
                if (res_ch.window_last !== want.last) begin
                    $error("window_last: expected %0d, got %0d", want.last, res_ch.window_last);
                    fail_count++;
                end
                if (res_ch.windows_done !== want.done) begin
                    $error("windows_done: expected %0d, got %0d", want.done, res_ch.windows_done);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int rnd_count;
        int roll;
        int rpct;
        logic [OP_W-1:0] op;
        rnd_count = 0;
        in_ch.valid          <= 1'b0;
        in_ch.operation      <= OP_DATA;
        in_ch.sample_word    <= '0;
        in_ch.transfer_start <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_IDLE_TAG;
        cfg_ch.data  <= '0;
        i_rst_n <= 1'b0;
        idle_tag_q = RST_IDLE_TAG;
        tag_mask_q = RST_TAG_MASK;
        tag_base_q = RST_TAG_BASE;
        synced_q   = 1'b0;
        phase_q    = '0;
        fill_q     = '0;
        windows_q  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++)
            send_item(DIRECTED[r].op, DIRECTED[r].word, DIRECTED[r].start,
                      DIRECTED[r].typed, DIRECTED[r].has_res, DIRECTED[r].res);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (PHASES[p].rnd)
                write_tags(WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
            else
                write_tags(PHASES[p].idle, PHASES[p].mask, PHASES[p].base);
            rpct = int'(PHASES[p].realign_pct);
            if (PHASES[p].resync)
                send_item(OP_REALIGN, WORD_W'($urandom), 1'($urandom), 1'b0, 1'b0, NO_RES);
            for (int k = 0; k < int'(PHASES[p].items); k++) begin
                case ((rnd_count / IDLE_BLOCK) % 4)
                    0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                    1: begin send_idle_pct = 69; sink_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  sink_stall_pct = 69; end
                    default: begin send_idle_pct = 32; sink_stall_pct = 32; end
                endcase
                roll = int'($urandom_range(99));
                if (roll < rpct)
                    op = OP_REALIGN;
                else if (roll < rpct + 2)
                    op = OP_CLEAR;
                else if (roll < rpct + 3)
                    op = OP_UNUSED;
                else
                    op = OP_DATA;
                send_item(op, pick_word(), $urandom_range(9) == 0, 1'b0, 1'b0, NO_RES);
                rnd_count++;
            end
        end
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
